FILE: design/cocktail_shaker_sorter_core_defines.svh
// assertion macros used by the sorter controller
`ifndef COCKTAIL_SHAKER_SORTER_CORE_DEFINES_SVH
`define COCKTAIL_SHAKER_SORTER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/css_pkg.sv
`timescale 1ns / 1ps

package css_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W       = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } result_t;

  // controller to cell row and result register
  typedef struct packed {
    logic insert;
    logic shift;
    logic done;
    logic last_out;
    logic overflow;
  } ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

endpackage

FILE: design/css_cell.sv
`timescale 1ns / 1ps

module css_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 shift,
  input  logic                                 carry_in_valid,
  input  logic signed [css_pkg::DATA_W-1:0]    carry_in_value,
  input  logic                                 next_valid,
  input  logic signed [css_pkg::DATA_W-1:0]    next_value,
  output logic                                 stored_valid,
  output logic signed [css_pkg::DATA_W-1:0]    stored_value,
  output logic                                 carry_out_valid,
  output logic signed [css_pkg::DATA_W-1:0]    carry_out_value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_valid    <= 1'b0;
      carry_out_valid <= 1'b0;
    end else if (shift) begin
      // drain: move one place toward the head
      stored_valid    <= next_valid;
      carry_out_valid <= 1'b0;
    end else if (carry_in_valid) begin
      stored_valid    <= 1'b1;
      carry_out_valid <= stored_valid;
    end else begin
      carry_out_valid <= 1'b0;
    end
  end

  // drain takes the next cell's value; otherwise keep the smaller value, hand the larger one on
  always_ff @(posedge clk) begin
    if (shift) begin
      stored_value <= next_value;
    end else if (carry_in_valid) begin
      if (!stored_valid) begin
        stored_value <= carry_in_value;
      end else if (carry_in_value < stored_value) begin
        stored_value    <= carry_in_value;
        carry_out_value <= stored_value;
      end else begin
        carry_out_value <= carry_in_value;
      end
    end
  end

endmodule

FILE: design/css_ctrl.sv
`timescale 1ns / 1ps
`include "cocktail_shaker_sorter_core_defines.svh"

module css_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last,
  output logic           busy,
  output css_pkg::ctrl_t ctrl
);

  localparam logic [css_pkg::CNT_W-1:0] CntMax = css_pkg::CNT_W'(css_pkg::MAX_ELEMENTS);
  localparam logic [css_pkg::CNT_W-1:0] CntOne = css_pkg::CNT_W'(1);

  css_pkg::state_t              state, state_next;
  logic [css_pkg::CNT_W-1:0]    count, count_next;
  logic [css_pkg::CNT_W-1:0]    settle, settle_next;
  logic [css_pkg::CNT_W-1:0]    remaining, remaining_next;
  logic                         ovf, ovf_next;
  logic                         done, done_next;
  logic                         last_out, last_out_next;
  logic                         ovf_out, ovf_out_next;
  logic                         accept;
  logic                         insert;

  assign busy   = (state != css_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign insert = accept && (count != CntMax);

  always_comb begin
    state_next     = state;
    count_next     = count;
    settle_next    = settle;
    remaining_next = remaining;
    ovf_next       = ovf;
    done_next      = 1'b0;
    last_out_next  = 1'b0;
    ovf_out_next   = 1'b0;
    unique case (state)
      css_pkg::ST_IDLE: begin
        if (accept) begin
          if (insert) begin
            count_next = count + CntOne;
          end else begin
            ovf_next = 1'b1;
          end
          if (last) begin
            state_next     = css_pkg::ST_SETTLE;
            settle_next    = insert ? count + CntOne : count;
            remaining_next = insert ? count + CntOne : count;
          end
        end
      end
      css_pkg::ST_SETTLE: begin
        // let the last carries ripple down the row
        if (settle == '0) begin
          state_next = css_pkg::ST_DRAIN;
        end else begin
          settle_next = settle - CntOne;
        end
      end
      css_pkg::ST_DRAIN: begin
        done_next      = 1'b1;
        last_out_next  = (remaining == CntOne);
        ovf_out_next   = ovf;
        remaining_next = remaining - CntOne;
        if (remaining == CntOne) begin
          state_next = css_pkg::ST_IDLE;
          count_next = '0;
          ovf_next   = 1'b0;
        end
      end
      default: begin
        state_next = css_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= css_pkg::ST_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      done     <= 1'b0;
      last_out <= 1'b0;
      ovf_out  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf      <= ovf_next;
      done     <= done_next;
      last_out <= last_out_next;
      ovf_out  <= ovf_out_next;
    end
  end

  always_ff @(posedge clk) begin
    settle    <= settle_next;
    remaining <= remaining_next;
  end

  assign ctrl.insert   = insert;
  assign ctrl.shift    = (state == css_pkg::ST_DRAIN);
  assign ctrl.done     = done;
  assign ctrl.last_out = last_out;
  assign ctrl.overflow = ovf_out;

  `CSS_ASSERT_IMPL(a_drain_nonempty, clk, rst, state == css_pkg::ST_DRAIN, remaining != '0)
  `CSS_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CntMax)
  `CSS_ASSERT_NEXT(a_drain_end, clk, rst, state == css_pkg::ST_DRAIN && remaining == CntOne, state == css_pkg::ST_IDLE && count == '0 && done && last_out)
  `CSS_ASSERT_NEXT(a_close_busy, clk, rst, accept && last, busy && !done)

endmodule

FILE: design/cocktail_shaker_sorter_core.sv
`timescale 1ns / 1ps

// loading: one value per cycle, a row of 64 compare-swap cells sorts while it fills
// after the closing beat: the cell row settles, then n results on
// consecutive cycles (n = values stored, at most 64)
// busy is high while the row settles and drains, low once the final result is shown; results cannot stall
// synchronous active-high reset empties the row and clears count and overflow state

module cocktail_shaker_sorter_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  css_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output css_pkg::result_t result
);

  localparam int N = css_pkg::MAX_ELEMENTS;

  css_pkg::ctrl_t                       ctrl;
  logic                                 cell_valid [N];
  logic signed [css_pkg::DATA_W-1:0]    cell_value [N];
  logic                                 carry_valid [N];
  logic signed [css_pkg::DATA_W-1:0]    carry_value [N];
  logic signed [css_pkg::DATA_W-1:0]    head_value;

  css_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (item.last),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                              cin_valid;
    logic signed [css_pkg::DATA_W-1:0] cin_value;
    logic                              nxt_valid;
    logic signed [css_pkg::DATA_W-1:0] nxt_value;

    if (i == 0) begin : g_head
      assign cin_valid = ctrl.insert;
      assign cin_value = item.value;
    end else begin : g_body
      assign cin_valid = carry_valid[i-1];
      assign cin_value = carry_value[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_value = '0;
    end else begin : g_link
      assign nxt_valid = cell_valid[i+1];
      assign nxt_value = cell_value[i+1];
    end

    css_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .shift           (ctrl.shift),
      .carry_in_valid  (cin_valid),
      .carry_in_value  (cin_value),
      .next_valid      (nxt_valid),
      .next_value      (nxt_value),
      .stored_valid    (cell_valid[i]),
      .stored_value    (cell_value[i]),
      .carry_out_valid (carry_valid[i]),
      .carry_out_value (carry_value[i])
    );
  end

  // head of the row is the next smallest value
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      head_value <= cell_value[0];
    end
  end

  assign done                = ctrl.done;
  assign result.sorted_value = head_value;
  assign result.last_out     = ctrl.last_out;
  assign result.overflow     = ctrl.overflow;

endmodule
